FILE: hdl/mct_pkg.sv
// Shared constants, codes and the clamp helper function of the mouse cursor tracker.
`timescale 1ns / 1ps
package mct_pkg;

   // Number of buttons tracked by default.
   localparam int BUTTON_COUNT_DEFAULT = 3;

   // Field widths.
   localparam int POS_W   = 16;
   localparam int RATIO_W = 15;
   localparam int MAG_W   = 16;
   localparam int WIDE_W  = 18;
   localparam int MASK_W  = 7;
   localparam int CSR_IDX_W = 3;

   // Reset and soft reset values.
   localparam logic signed [POS_W-1:0] HOME_X = 16'sd320;
   localparam logic signed [POS_W-1:0] HOME_Y = 16'sd100;
   localparam logic signed [POS_W-1:0] X_HIGH_RESET = 16'sd639;
   localparam logic signed [POS_W-1:0] Y_HIGH_RESET = 16'sd199;
   localparam logic [RATIO_W-1:0] X_RATIO_RESET = 15'd8;
   localparam logic [RATIO_W-1:0] Y_RATIO_RESET = 15'd16;
   localparam logic [15:0] SOFT_RESET_CODE = 16'd3;

   // Command codes.
   localparam logic [2:0] FUNC_REPORT  = 3'd0;
   localparam logic [2:0] FUNC_SET_POS = 3'd1;
   localparam logic [2:0] FUNC_STATUS  = 3'd2;
   localparam logic [2:0] FUNC_PRESS   = 3'd3;
   localparam logic [2:0] FUNC_RELEASE = 3'd4;
   localparam logic [2:0] FUNC_MICKEYS = 3'd5;
   localparam logic [2:0] FUNC_SOFT    = 3'd6;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_X_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_X_RATIO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Y_RATIO = 3'd5;

   // Clamp a wide position into the range, the smaller bound taken as low.
   function automatic logic signed [POS_W-1:0] clamp_axis(
      input logic signed [WIDE_W-1:0] v,
      input logic signed [POS_W-1:0]  a,
      input logic signed [POS_W-1:0]  b);
      logic signed [WIDE_W-1:0] lo;
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] r;
      lo = (a < b) ? WIDE_W'(a) : WIDE_W'(b);
      hi = (a < b) ? WIDE_W'(b) : WIDE_W'(a);
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r[POS_W-1:0];
   endfunction

endpackage

FILE: hdl/mct_if.sv
// Handshake channel interfaces of the mouse cursor tracker.
`timescale 1ns / 1ps

// Input item channel: one report or command.
interface mct_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        func;
   logic [2:0]        report_buttons;
   logic signed [7:0] report_dx;
   logic signed [7:0] report_dy;
   logic signed [15:0] new_x;
   logic signed [15:0] new_y;
   logic [1:0]        button_select;
   modport source (output valid, func, report_buttons, report_dx, report_dy,
                   new_x, new_y, button_select, input ready);
   modport sink (input valid, func, report_buttons, report_dx, report_dy,
                 new_x, new_y, button_select, output ready);
endinterface

// Result item channel.
interface mct_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         button_state;
   logic signed [15:0] x_value;
   logic signed [15:0] y_value;
   logic [15:0]        event_count;
   logic [6:0]         event_mask;
   modport source (output valid, button_state, x_value, y_value, event_count,
                   event_mask, input ready);
   modport sink (input valid, button_state, x_value, y_value, event_count,
                 event_mask, output ready);
endinterface

// Register write channel.
interface mct_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/mct_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module mct_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mct_pkg::MAG_W-1:0]     dividend,
   input  logic [mct_pkg::RATIO_W-1:0]   divisor,
   output logic                          done,
   output logic [mct_pkg::MAG_W-1:0]     quotient,
   output logic [mct_pkg::RATIO_W-1:0]   remainder
);
   import mct_pkg::*;

   localparam int CNT_W = $clog2(MAG_W);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MAG_W-1:0]   work_ff, work_in;
   logic [RATIO_W-1:0] rem_ff, rem_in;
   logic [RATIO_W-1:0] div_ff, div_in;
   logic [RATIO_W:0]   trial;
   logic [RATIO_W+1:0] diff;

   // One step: bring down the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, work_ff[MAG_W-1]};
      diff = {1'b0, trial} - {2'b00, div_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      work_in = work_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         work_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[MAG_W-2:0], ~diff[RATIO_W+1]};
         rem_in = diff[RATIO_W+1] ? trial[RATIO_W-1:0] : diff[RATIO_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MAG_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   // Results are in the registers from the edge after the last step.
   assign done = busy_ff && (cnt_ff == CNT_W'(MAG_W - 1));
   assign quotient = work_ff;
   assign remainder = rem_ff;
endmodule

FILE: hdl/mouse_cursor_tracker.sv
// Top level of the mouse cursor tracker.
`timescale 1ns / 1ps
// A report with motion passes the divide state: the two axis divisions run
// side by side in bit-serial dividers, one quotient bit a cycle, then the
// apply state applies the update. Every other item goes straight to the
// apply state. One item is worked on at a time; the next is taken once the
// result register has been loaded, even while it waits to be read.
// Register writes are taken in any cycle and should be made while idle.
module mouse_cursor_tracker #(
   parameter int BUTTON_COUNT = mct_pkg::BUTTON_COUNT_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   mct_req_if.sink   req_if,
   mct_rsp_if.source rsp_if,
   mct_csr_if.sink   csr_if
);
   import mct_pkg::*;

   localparam int SEL_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_APPLY} state_type;

   state_type state_ff;

   // Configuration registers.
   logic signed [POS_W-1:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff;
   logic [RATIO_W-1:0]      x_ratio_ff, y_ratio_ff;

   // Tracker state.
   logic signed [POS_W-1:0] cursor_x_ff, cursor_y_ff, carry_x_ff, carry_y_ff;
   logic [POS_W-1:0]        sum_x_ff, sum_y_ff;
   logic [BUTTON_COUNT-1:0] held_ff;
   logic [15:0]             press_num_ff [BUTTON_COUNT];
   logic [15:0]             release_cnt_ff [BUTTON_COUNT];
   logic signed [POS_W-1:0] press_x_ff [BUTTON_COUNT];
   logic signed [POS_W-1:0] press_y_ff [BUTTON_COUNT];
   logic signed [POS_W-1:0] release_x_ff [BUTTON_COUNT];
   logic signed [POS_W-1:0] release_y_ff [BUTTON_COUNT];

   // Latched item.
   logic [2:0]              func_ff;
   logic [BUTTON_COUNT-1:0] buttons_ff;
   logic signed [7:0]       dx_ff, dy_ff;
   logic signed [POS_W-1:0] new_x_ff, new_y_ff;
   logic [SEL_W-1:0]        sel_ff;
   logic                    motion_ff, neg_x_ff, neg_y_ff;

   // Result register.
   logic                    rsp_valid_ff;
   logic [2:0]              rsp_buttons_ff;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [15:0]             rsp_count_ff;
   logic [MASK_W-1:0]       rsp_mask_ff;

   logic accept, apply, start, motion_in, done_x, done_y;
   logic signed [WIDE_W-1:0] n_x, n_y;
   logic [MAG_W-1:0]   mag_x, mag_y, quo_x, quo_y;
   logic [RATIO_W-1:0] rem_x, rem_y;
   logic [SEL_W-1:0]   sel_in;

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign apply = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_if.ready);

   // Scaled motion plus carry; its magnitude goes to the dividers.
   always_comb begin
      motion_in = (req_if.report_dx != 8'sd0) || (req_if.report_dy != 8'sd0);
      n_x = WIDE_W'(req_if.report_dx) * 18'sd8 + WIDE_W'(carry_x_ff);
      n_y = WIDE_W'(req_if.report_dy) * 18'sd8 + WIDE_W'(carry_y_ff);
      mag_x = n_x[WIDE_W-1] ? MAG_W'(-n_x) : MAG_W'(n_x);
      mag_y = n_y[WIDE_W-1] ? MAG_W'(-n_y) : MAG_W'(n_y);
      start = accept && (req_if.func == FUNC_REPORT) && motion_in;
      if (int'(req_if.button_select) >= BUTTON_COUNT) sel_in = SEL_W'(BUTTON_COUNT - 1);
      else sel_in = SEL_W'(req_if.button_select);
   end

   mct_divider u_div_x (
      .clock, .reset, .start, .dividend(mag_x), .divisor(x_ratio_ff),
      .done(done_x), .quotient(quo_x), .remainder(rem_x)
   );

   mct_divider u_div_y (
      .clock, .reset, .start, .dividend(mag_y), .divisor(y_ratio_ff),
      .done(done_y), .quotient(quo_y), .remainder(rem_y)
   );

   // Next state of the tracker for the item in hand.
   logic signed [POS_W-1:0] cx_in, cy_in, kx_in, ky_in;
   logic [POS_W-1:0]        sx_in, sy_in;
   logic [BUTTON_COUNT-1:0] held_in, change;
   logic [15:0]             pc_in [BUTTON_COUNT];
   logic [15:0]             rc_in [BUTTON_COUNT];
   logic signed [POS_W-1:0] px_in [BUTTON_COUNT];
   logic signed [POS_W-1:0] py_in [BUTTON_COUNT];
   logic signed [POS_W-1:0] qx_in [BUTTON_COUNT];
   logic signed [POS_W-1:0] qy_in [BUTTON_COUNT];
   logic signed [POS_W-1:0] ox_in, oy_in;
   logic [15:0]             cnt_in;
   logic [MASK_W-1:0]       mask_in;
   logic signed [WIDE_W-1:0] step_x, step_y;

   always_comb begin
      step_x = neg_x_ff ? -WIDE_W'(quo_x) : WIDE_W'(quo_x);
      step_y = neg_y_ff ? -WIDE_W'(quo_y) : WIDE_W'(quo_y);
      cx_in = cursor_x_ff;
      cy_in = cursor_y_ff;
      kx_in = carry_x_ff;
      ky_in = carry_y_ff;
      sx_in = sum_x_ff;
      sy_in = sum_y_ff;
      held_in = held_ff;
      change = '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         pc_in[i] = press_num_ff[i];
         rc_in[i] = release_cnt_ff[i];
         px_in[i] = press_x_ff[i];
         py_in[i] = press_y_ff[i];
         qx_in[i] = release_x_ff[i];
         qy_in[i] = release_y_ff[i];
      end
      cnt_in = '0;
      mask_in = '0;
      ox_in = cursor_x_ff;
      oy_in = cursor_y_ff;
      case (func_ff)
         FUNC_REPORT: begin
            if (motion_ff) begin
               sx_in = sum_x_ff + POS_W'(dx_ff);
               sy_in = sum_y_ff + POS_W'(dy_ff);
               cx_in = clamp_axis(WIDE_W'(cursor_x_ff) + step_x, x_lo_ff, x_hi_ff);
               cy_in = clamp_axis(WIDE_W'(cursor_y_ff) + step_y, y_lo_ff, y_hi_ff);
               kx_in = neg_x_ff ? -POS_W'(rem_x) : POS_W'(rem_x);
               ky_in = neg_y_ff ? -POS_W'(rem_y) : POS_W'(rem_y);
               mask_in[0] = 1'b1;
            end
            change = buttons_ff ^ held_ff;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
               if (change[i] && buttons_ff[i]) begin
                  pc_in[i] = press_num_ff[i] + 16'd1;
                  px_in[i] = cx_in;
                  py_in[i] = cy_in;
                  mask_in[1 + 2 * i] = 1'b1;
               end else if (change[i]) begin
                  rc_in[i] = release_cnt_ff[i] + 16'd1;
                  qx_in[i] = cx_in;
                  qy_in[i] = cy_in;
                  mask_in[2 + 2 * i] = 1'b1;
               end
            end
            held_in = buttons_ff;
            ox_in = cx_in;
            oy_in = cy_in;
         end
         FUNC_SET_POS: begin
            cx_in = clamp_axis(WIDE_W'(new_x_ff), x_lo_ff, x_hi_ff);
            cy_in = clamp_axis(WIDE_W'(new_y_ff), y_lo_ff, y_hi_ff);
            ox_in = cx_in;
            oy_in = cy_in;
         end
         FUNC_PRESS: begin
            cnt_in = press_num_ff[sel_ff];
            pc_in[sel_ff] = '0;
            ox_in = press_x_ff[sel_ff];
            oy_in = press_y_ff[sel_ff];
         end
         FUNC_RELEASE: begin
            cnt_in = release_cnt_ff[sel_ff];
            rc_in[sel_ff] = '0;
            ox_in = release_x_ff[sel_ff];
            oy_in = release_y_ff[sel_ff];
         end
         FUNC_MICKEYS: begin
            ox_in = sum_x_ff;
            oy_in = sum_y_ff;
            sx_in = '0;
            sy_in = '0;
         end
         FUNC_SOFT: begin
            cx_in = HOME_X;
            cy_in = HOME_Y;
            sx_in = '0;
            sy_in = '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
               pc_in[i] = '0;
               rc_in[i] = '0;
               px_in[i] = '0;
               py_in[i] = '0;
               qx_in[i] = '0;
               qy_in[i] = '0;
            end
            cnt_in = SOFT_RESET_CODE;
            ox_in = HOME_X;
            oy_in = HOME_Y;
         end
         default: begin
         end
      endcase
   end

   // Sequencer, tracker state, configuration and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_lo_ff <= '0;
         x_hi_ff <= X_HIGH_RESET;
         y_lo_ff <= '0;
         y_hi_ff <= Y_HIGH_RESET;
         x_ratio_ff <= X_RATIO_RESET;
         y_ratio_ff <= Y_RATIO_RESET;
         cursor_x_ff <= HOME_X;
         cursor_y_ff <= HOME_Y;
         carry_x_ff <= '0;
         carry_y_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         held_ff <= '0;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            press_num_ff[i] <= '0;
            release_cnt_ff[i] <= '0;
            press_x_ff[i] <= '0;
            press_y_ff[i] <= '0;
            release_x_ff[i] <= '0;
            release_y_ff[i] <= '0;
         end
      end else begin
         if (csr_if.valid) begin
            case (csr_if.index)
               REG_X_LOW:  x_lo_ff <= csr_if.data;
               REG_X_HIGH: x_hi_ff <= csr_if.data;
               REG_Y_LOW:  y_lo_ff <= csr_if.data;
               REG_Y_HIGH: y_hi_ff <= csr_if.data;
               REG_X_RATIO: begin
                  if (csr_if.data[RATIO_W-1:0] != '0) x_ratio_ff <= csr_if.data[RATIO_W-1:0];
               end
               REG_Y_RATIO: begin
                  if (csr_if.data[RATIO_W-1:0] != '0) y_ratio_ff <= csr_if.data[RATIO_W-1:0];
               end
               default: begin
               end
            endcase
         end
         // A new result is loaded on apply; otherwise a read empties the register.
         if (apply) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) state_ff <= start ? ST_DIVIDE : ST_APPLY;
            end
            ST_DIVIDE: begin
               if (done_x && done_y) state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (apply) begin
                  state_ff <= ST_IDLE;
                  cursor_x_ff <= cx_in;
                  cursor_y_ff <= cy_in;
                  carry_x_ff <= kx_in;
                  carry_y_ff <= ky_in;
                  sum_x_ff <= sx_in;
                  sum_y_ff <= sy_in;
                  held_ff <= held_in;
                  for (int i = 0; i < BUTTON_COUNT; i++) begin
                     press_num_ff[i] <= pc_in[i];
                     release_cnt_ff[i] <= rc_in[i];
                     press_x_ff[i] <= px_in[i];
                     press_y_ff[i] <= py_in[i];
                     release_x_ff[i] <= qx_in[i];
                     release_y_ff[i] <= qy_in[i];
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      // Item payload and result payload carry no reset.
      if (accept) begin
         func_ff <= req_if.func;
         buttons_ff <= req_if.report_buttons[BUTTON_COUNT-1:0];
         dx_ff <= req_if.report_dx;
         dy_ff <= req_if.report_dy;
         new_x_ff <= req_if.new_x;
         new_y_ff <= req_if.new_y;
         sel_ff <= sel_in;
         motion_ff <= motion_in;
         neg_x_ff <= n_x[WIDE_W-1];
         neg_y_ff <= n_y[WIDE_W-1];
      end
      if (apply) begin
         rsp_buttons_ff <= 3'(held_in);
         rsp_x_ff <= ox_in;
         rsp_y_ff <= oy_in;
         rsp_count_ff <= cnt_in;
         rsp_mask_ff <= mask_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.button_state = rsp_buttons_ff;
   assign rsp_if.x_value = rsp_x_ff;
   assign rsp_if.y_value = rsp_y_ff;
   assign rsp_if.event_count = rsp_count_ff;
   assign rsp_if.event_mask = rsp_mask_ff;
endmodule

FILE: sim/tb_mouse_cursor_tracker.sv
// Self-checking testbench of the mouse cursor tracker against a predictor.
`timescale 1ns / 1ps
module tb_mouse_cursor_tracker;
   import mct_pkg::*;

   // One command or report as offered on the request channel.
   typedef struct {
      logic [2:0]         func;
      logic [2:0]         buttons;
      logic signed [7:0]  dx;
      logic signed [7:0]  dy;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [1:0]         sel;
   } cmd_type;

   // One result as seen on the response channel.
   typedef struct {
      logic [2:0]  buttons;
      logic [15:0] xv;
      logic [15:0] yv;
      logic [15:0] count;
      logic [6:0]  mask;
   } answer_type;

   logic clock;
   logic reset;

   mct_req_if req_if ();
   mct_rsp_if rsp_if ();
   mct_csr_if csr_if ();

   mouse_cursor_tracker DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Predictor state: registers and tracker state.
   int bound_q[4];
   int ratio_q[2];
   int pos_x, pos_y, rem_x, rem_y;
   logic [15:0] sum_x, sum_y;
   logic [2:0] held;
   logic [15:0] press_num[3], release_cnt[3];
   int press_x[3], press_y[3], release_x[3], release_y[3];

   cmd_type    pending_cmds[$];
   answer_type expected_answers[$];
   int      errors;
   int      hold_cycles;
   int      gap_left;
   int      stall_left;
   bit      long_hold;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   initial begin
      #200ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int clamp_to(int v, int a, int b);
      int lo;
      int hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic void clear_tracker();
      pos_x = 320;
      pos_y = 100;
      sum_x = '0;
      sum_y = '0;
      for (int i = 0; i < 3; i++) begin
         press_num[i] = '0;
         release_cnt[i] = '0;
         press_x[i] = 0;
         press_y[i] = 0;
         release_x[i] = 0;
         release_y[i] = 0;
      end
   endfunction

   // Work out the result of one accepted item and advance the state.
   function automatic answer_type track_item(cmd_type c);
      answer_type a;
      int n;
      int s;
      int xv;
      int yv;
      logic [2:0] chg;
      a.count = '0;
      a.mask = '0;
      s = (c.sel > 2) ? 2 : c.sel;
      xv = pos_x;
      yv = pos_y;
      case (c.func)
         FUNC_REPORT: begin
            if (c.dx != 0 || c.dy != 0) begin
               sum_x = sum_x + 16'(c.dx);
               sum_y = sum_y + 16'(c.dy);
               n = int'(c.dx) * 8 + rem_x;
               pos_x += n / ratio_q[0];
               rem_x = n % ratio_q[0];
               n = int'(c.dy) * 8 + rem_y;
               pos_y += n / ratio_q[1];
               rem_y = n % ratio_q[1];
               pos_x = clamp_to(pos_x, bound_q[0], bound_q[1]);
               pos_y = clamp_to(pos_y, bound_q[2], bound_q[3]);
               a.mask[0] = 1'b1;
            end
            chg = c.buttons ^ held;
            for (int i = 0; i < 3; i++) begin
               if (chg[i]) begin
                  if (c.buttons[i]) begin
                     press_num[i]++;
                     press_x[i] = pos_x;
                     press_y[i] = pos_y;
                     a.mask[1 + 2 * i] = 1'b1;
                  end else begin
                     release_cnt[i]++;
                     release_x[i] = pos_x;
                     release_y[i] = pos_y;
                     a.mask[2 + 2 * i] = 1'b1;
                  end
               end
            end
            held = c.buttons;
            xv = pos_x;
            yv = pos_y;
         end
         FUNC_SET_POS: begin
            pos_x = clamp_to(c.nx, bound_q[0], bound_q[1]);
            pos_y = clamp_to(c.ny, bound_q[2], bound_q[3]);
            xv = pos_x;
            yv = pos_y;
         end
         FUNC_PRESS: begin
            a.count = press_num[s];
            press_num[s] = '0;
            xv = press_x[s];
            yv = press_y[s];
         end
         FUNC_RELEASE: begin
            a.count = release_cnt[s];
            release_cnt[s] = '0;
            xv = release_x[s];
            yv = release_y[s];
         end
         FUNC_MICKEYS: begin
            xv = sum_x;
            yv = sum_y;
            sum_x = '0;
            sum_y = '0;
         end
         FUNC_SOFT: begin
            clear_tracker();
            a.count = SOFT_RESET_CODE;
            xv = pos_x;
            yv = pos_y;
         end
         default: ;
      endcase
      a.buttons = held;
      a.xv = 16'(xv);
      a.yv = 16'(yv);
      return a;
   endfunction

   // Driver: offers queued items with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left <= 0;
      end else if (req_if.valid && !req_if.ready) begin
         // Holding the offered item.
      end else if (gap_left > 0) begin
         req_if.valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_cmds.size() > 0) begin
         cmd_type c;
         c = pending_cmds.pop_front();
         req_if.valid <= 1'b1;
         req_if.func <= c.func;
         req_if.report_buttons <= c.buttons;
         req_if.report_dx <= c.dx;
         req_if.report_dy <= c.dy;
         req_if.new_x <= c.nx;
         req_if.new_y <= c.ny;
         req_if.button_select <= c.sel;
         expected_answers.push_back(track_item(c));
         gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Monitor and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
         hold_cycles <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected result x=%0d", $time, rsp_if.x_value);
               errors++;
            end else begin
               answer_type e;
               e = expected_answers.pop_front();
               if (e.buttons !== rsp_if.button_state || e.xv !== rsp_if.x_value ||
                   e.yv !== rsp_if.y_value || e.count !== rsp_if.event_count ||
                   e.mask !== rsp_if.event_mask) begin
                  $display("%0t: expected b=%0h x=%0h y=%0h c=%0h m=%0h", $time,
                           e.buttons, e.xv, e.yv, e.count, e.mask);
                  $display("%0t: actual   b=%0h x=%0h y=%0h c=%0h m=%0h", $time,
                           rsp_if.button_state, rsp_if.x_value, rsp_if.y_value,
                           rsp_if.event_count, rsp_if.event_mask);
                  errors++;
               end
            end
         end
         if (long_hold && hold_cycles < 400) begin
            hold_cycles <= hold_cycles + 1;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_if.valid && rsp_if.ready)
               stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end
      end
   end

   function automatic cmd_type make_cmd(logic [2:0] f);
      cmd_type c;
      c.func = f;
      c.buttons = 3'($urandom);
      c.dx = 8'($urandom);
      c.dy = 8'($urandom);
      c.nx = 16'($urandom);
      c.ny = 16'($urandom);
      c.sel = 2'($urandom);
      return c;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx < REG_X_RATIO) bound_q[idx] = int'($signed(val));
      else if (val[14:0] != 0) ratio_q[idx - REG_X_RATIO] = val[14:0];
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || expected_answers.size() > 0 || req_if.valid)
         @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   // Mostly reports with small motion, spread with queries.
   function automatic cmd_type random_cmd();
      cmd_type c;
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) c = make_cmd(FUNC_REPORT);
      else if (r < 95) c = make_cmd(3'($urandom_range(1, 5)));
      else c = make_cmd(3'($urandom_range(6, 7)));
      if (r < 40) begin
         c.dx = 8'($signed($urandom_range(0, 20)) - 10);
         c.dy = 8'($signed($urandom_range(0, 20)) - 10);
      end
      return c;
   endfunction

   initial begin
      cmd_type c;
      logic [15:0] cfg[6];
      errors = 0;
      long_hold = 0;
      reset = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      req_if.valid = 1'b0;
      req_if.func = '0;
      req_if.report_buttons = '0;
      req_if.report_dx = '0;
      req_if.report_dy = '0;
      req_if.new_x = '0;
      req_if.new_y = '0;
      req_if.button_select = '0;
      rsp_if.ready = 1'b0;
      bound_q = '{0, 639, 0, 199};
      ratio_q = '{8, 16};
      rem_x = 0;
      rem_y = 0;
      held = '0;
      clear_tracker();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: every command, extreme motion, button edges, select three.
      for (int f = 0; f < 8; f++) pending_cmds.push_back(make_cmd(3'(f)));
      c = make_cmd(FUNC_REPORT); c.dx = 8'sh7f; c.dy = 8'sh80; c.buttons = 3'b111;
      pending_cmds.push_back(c);
      c.dx = 8'sh80; c.dy = 8'sh7f; c.buttons = 3'b000;
      pending_cmds.push_back(c);
      c.dx = 0; c.dy = 0; c.buttons = 3'b101;
      pending_cmds.push_back(c);
      c = make_cmd(FUNC_SET_POS); c.nx = 16'sh7fff; c.ny = 16'sh8000;
      pending_cmds.push_back(c);
      for (int s = 0; s < 4; s++) begin
         c = make_cmd(FUNC_PRESS); c.sel = 2'(s); pending_cmds.push_back(c);
         c.func = FUNC_RELEASE; pending_cmds.push_back(c);
      end
      drain();

      // Phases of register settings, extremes and swapped bounds included.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: cfg = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'd1, 16'h7fff};
            1: cfg = '{16'd100, 16'hff9c, 16'd50, 16'd0, 16'h7fff, 16'd1};
            2: cfg = '{16'd0, 16'd0, 16'd5, 16'd5, 16'd0, 16'h8000};
            default: cfg = '{16'($urandom_range(0, 400)) - 16'd200,
                             16'($urandom_range(0, 1000)),
                             16'($urandom_range(0, 400)) - 16'd200,
                             16'($urandom_range(0, 1000)),
                             16'($urandom_range(1, 40)), 16'($urandom_range(1, 40))};
         endcase
         for (int i = 0; i < 6; i++) write_reg(3'(i), cfg[i]);
         for (int k = 0; k < 280; k++) pending_cmds.push_back(random_cmd());
         if (ph == 3) begin
            long_hold = 1;
            while (hold_cycles < 400) @(posedge clock);
            long_hold = 0;
         end
         drain();
      end

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

FILE: mouse_cursor_tracker.f
hdl/mct_pkg.sv
hdl/mct_if.sv
hdl/mct_divider.sv
hdl/mouse_cursor_tracker.sv
sim/tb_mouse_cursor_tracker.sv
